[hdl/mandelbrot_escape_pixel_unit_defines.svh]
// Assertion macros for the escape-time pixel unit.
// Included by modules that carry concurrent checks; expects aclk and aresetn in scope.
`ifndef MANDELBROT_ESCAPE_PIXEL_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_PIXEL_UNIT_DEFINES_SVH

// check out of reset
`define MEP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check on every edge, reset included
`define MEP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hdl/mep_pkg.sv]
// Shared constants, types and helper functions of the escape-time pixel unit.
// No dependencies; used by mep_div and mandelbrot_escape_pixel_unit.
`timescale 1ns / 1ps
`default_nettype none

package mep_pkg;

    localparam int MAX_ITERATIONS  = 35;
    localparam int COORD_FRAC_BITS = 28;
    localparam int DIM_BITS        = 12;

    localparam int COORD_W    = COORD_FRAC_BITS + 4;
    localparam int DEN_W      = DIM_BITS + 1;
    localparam int CFG_DATA_W = DEN_W;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_W      = DIM_BITS + 2;
    localparam int DVD_W      = NUM_W + COORD_FRAC_BITS;
    localparam int DVDX_W     = DVD_W + 1;
    localparam int CNT_W      = $clog2(DVD_W + 1);
    localparam int GREY_W     = 16;
    localparam int STEP_W     = $clog2(MAX_ITERATIONS + 1);
    localparam int MULB_W     = GREY_W + STEP_W;
    localparam int MUL_W      = ((COORD_W > 2 * GREY_W) ? COORD_W : 2 * GREY_W) + 1;
    localparam int PROD_W     = 2 * (MUL_W - 1);
    localparam int SUM_W      = PROD_W - COORD_FRAC_BITS + 1;
    localparam int ROOT_W     = 4 * GREY_W + MULB_W;

    localparam logic [DEN_W-1:0]   DIM_RESET  = DEN_W'(1024);
    localparam logic [COORD_W-1:0] COORD_MAX  = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN  = {1'b1, {(COORD_W - 1){1'b0}}};
    localparam logic [DVDX_W-1:0]  OFF_X      = DVDX_W'(2) << COORD_FRAC_BITS;
    localparam logic [DVDX_W-1:0]  OFF_Y      = DVDX_W'(3) << (COORD_FRAC_BITS - 1);
    localparam logic [PROD_W-1:0]  ESC_LIMIT  = PROD_W'(1) << (2 * COORD_FRAC_BITS + 2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_STEP,
        ST_SQ_X,
        ST_SQ_Y,
        ST_TEST,
        ST_R_G2,
        ST_R_G4,
        ST_R_LO,
        ST_R_HI,
        ST_R_CMP,
        ST_WRITE
    } mep_state_t;

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-COORD_W:0] top;
        top = v[SUM_W-1:COORD_W-1];
        if ((&top) || !(|top)) begin
            return v[COORD_W-1:0];
        end
        return v[SUM_W-1] ? COORD_MIN : COORD_MAX;
    endfunction

    function automatic logic signed [COORD_W-1:0] map_coord(input logic [DVD_W-1:0] q,
                                                            input logic [DVDX_W-1:0] off);
        logic [DVDX_W-1:0]         d;
        logic [DVDX_W-COORD_W:0]   top;
        d   = {1'b0, q} - off;
        top = d[DVDX_W-1:COORD_W-1];
        if ((&top) || !(|top)) begin
            return d[COORD_W-1:0];
        end
        return d[DVDX_W-1] ? COORD_MIN : COORD_MAX;
    endfunction

endpackage

`default_nettype wire

[hdl/mep_div.sv]
// Restoring shift-subtract divider, one quotient bit per cycle, fraction bits appended.
// Depends on mep_pkg for the operand and quotient widths.
`timescale 1ns / 1ps
`default_nettype none

module mep_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [mep_pkg::NUM_W-1:0]   num,
    input  logic [mep_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [mep_pkg::DVD_W-1:0]   quo
);
    import mep_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [DEN_W:0]     trial;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            dvd_next  = {num, {COORD_FRAC_BITS{1'b0}}};
            rem_next  = '0;
            den_next  = (den == '0) ? DEN_W'(1) : den;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = dvd_reg;

endmodule

`default_nettype wire

[hdl/mandelbrot_escape_pixel_unit.sv]
// Escape-time pixel unit: pixel to plane mapping, orbit iteration and grey root search.
// Depends on mep_pkg, mep_div and mandelbrot_escape_pixel_unit_defines.svh.
//
//   Channel   Dir   Transfer when           Payload
//   cfg       in    cfg_valid & cfg_ready   cfg_index, cfg_data
//   s         in    s_valid & s_ready       s_pixel_x, s_pixel_y
//   m         out   m_valid & m_ready       m_grey, m_escape_step
//
// One pixel at a time: two divides, orbit steps (STEP, SQ_X, SQ_Y, TEST) on the shared
// 33x33 multiplier, then 16 probes (R_G2, R_G4, R_LO, R_HI, R_CMP) for the grey root.
// The root search runs only for an escape at step k > 0; step 0 and no escape skip it.
// The unit takes the next input transfer only after the write, back in its idle state.
// Synchronous active-low reset; registers come back as 1024 x 1024, no result pending.
// A result waiting on m_ready holds the unit in its write state; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

`include "mandelbrot_escape_pixel_unit_defines.svh"

module mandelbrot_escape_pixel_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mep_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mep_pkg::DIM_BITS-1:0]      s_pixel_x,
    input  logic [mep_pkg::DIM_BITS-1:0]      s_pixel_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mep_pkg::GREY_W-1:0]        m_grey,
    output logic [mep_pkg::STEP_W-1:0]        m_escape_step
);
    import mep_pkg::*;

    mep_state_t                 state_reg, state_next;
    logic [DEN_W-1:0]           width_reg, width_next;
    logic [DEN_W-1:0]           height_reg, height_next;
    logic [DIM_BITS-1:0]        pix_y_reg, pix_y_next;
    logic signed [COORD_W-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic signed [COORD_W-1:0]  zx_reg, zx_next, zy_reg, zy_next;
    logic signed [PROD_W-1:0]   pa_reg, pa_next, pb_reg, pb_next, pc_reg, pc_next;
    logic [STEP_W-1:0]          iter_reg, iter_next, step_reg, step_next;
    logic [GREY_W-1:0]          lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [MULB_W-1:0]          b35_reg, b35_next;
    logic                       m_valid_reg, m_valid_next;
    logic [GREY_W-1:0]          m_grey_reg, m_grey_next;
    logic [STEP_W-1:0]          m_step_reg, m_step_next;

    logic                       div_start, div_done;
    logic [NUM_W-1:0]           div_num;
    logic [DEN_W-1:0]           div_den;
    logic [DVD_W-1:0]           div_quo;

    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [2*MUL_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]   dx;
    logic signed [SUM_W-1:0]    nx_sum, ny_sum;
    logic [PROD_W-1:0]          mag;
    logic [GREY_W:0]            mid_sum;
    logic [GREY_W-1:0]          mid, lo_new, hi_new;
    logic [ROOT_W-1:0]          root_total, root_thr;
    logic                       fits;

    mep_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign mul_p      = mul_a * mul_b;
    assign dx         = pa_reg - pb_reg;
    assign nx_sum     = SUM_W'(dx >>> COORD_FRAC_BITS) + SUM_W'(cx_reg);
    assign ny_sum     = SUM_W'(pc_reg >>> (COORD_FRAC_BITS - 1)) + SUM_W'(cy_reg);
    assign mag        = $unsigned(pa_reg) + $unsigned(pb_reg);
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg} + (GREY_W + 1)'(1);
    assign mid        = mid_sum[GREY_W:1];
    assign root_total = (ROOT_W'($unsigned(pc_reg)) << (2 * GREY_W)) + ROOT_W'($unsigned(pa_reg));
    assign root_thr   = {step_reg, {(5 * GREY_W){1'b0}}};
    assign fits       = root_total <= root_thr;
    assign lo_new     = fits ? mid_reg : lo_reg;
    assign hi_new     = fits ? hi_reg : mid_reg - GREY_W'(1);

    assign s_ready       = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_grey        = m_grey_reg;
    assign m_escape_step = m_step_reg;

    always_comb begin
        state_next   = state_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        pix_y_next   = pix_y_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        zx_next      = zx_reg;
        zy_next      = zy_reg;
        pa_next      = pa_reg;
        pb_next      = pb_reg;
        pc_next      = pc_reg;
        iter_next    = iter_reg;
        step_next    = step_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        b35_next     = b35_reg;
        m_valid_next = m_valid_reg;
        m_grey_next  = m_grey_reg;
        m_step_next  = m_step_reg;
        div_start    = 1'b0;
        div_num      = '0;
        div_den      = width_reg;
        mul_a        = '0;
        mul_b        = '0;

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_next  = cfg_data;
                CFG_IMAGE_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end

        // drop a result once its transfer completes
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pix_y_next = s_pixel_y;
                    div_start  = 1'b1;
                    div_num    = NUM_W'({s_pixel_x, 1'b0}) + NUM_W'(s_pixel_x);
                    div_den    = width_reg;
                    state_next = ST_DIV_X;
                end
            end
            ST_DIV_X: begin
                if (div_done) begin
                    cx_next    = map_coord(div_quo, OFF_X);
                    div_start  = 1'b1;
                    div_num    = NUM_W'({pix_y_reg, 1'b0}) + NUM_W'(pix_y_reg);
                    div_den    = height_reg;
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (div_done) begin
                    cy_next    = map_coord(div_quo, OFF_Y);
                    pa_next    = '0;
                    pb_next    = '0;
                    pc_next    = '0;
                    iter_next  = '0;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                zx_next    = sat_coord(nx_sum);
                zy_next    = sat_coord(ny_sum);
                state_next = ST_SQ_X;
            end
            ST_SQ_X: begin
                mul_a      = MUL_W'(zx_reg);
                mul_b      = MUL_W'(zx_reg);
                pa_next    = mul_p[PROD_W-1:0];
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                mul_a      = MUL_W'(zy_reg);
                mul_b      = MUL_W'(zy_reg);
                pb_next    = mul_p[PROD_W-1:0];
                state_next = ST_TEST;
            end
            ST_TEST: begin
                mul_a = MUL_W'(zx_reg);
                mul_b = MUL_W'(zy_reg);
                lo_next = '0;
                hi_next = '1;
                if (mag > ESC_LIMIT) begin
                    step_next  = iter_reg;
                    state_next = (iter_reg == '0) ? ST_WRITE : ST_R_G2;
                end else begin
                    pc_next = mul_p[PROD_W-1:0];
                    if (iter_reg == STEP_W'(MAX_ITERATIONS - 1)) begin
                        step_next  = STEP_W'(MAX_ITERATIONS);
                        state_next = ST_WRITE;
                    end else begin
                        iter_next  = iter_reg + STEP_W'(1);
                        state_next = ST_STEP;
                    end
                end
            end
            ST_R_G2: begin
                mul_a      = $signed(MUL_W'(mid));
                mul_b      = $signed(MUL_W'(mid));
                pa_next    = mul_p[PROD_W-1:0];
                mid_next   = mid;
                b35_next   = MULB_W'(mid) * MULB_W'(MAX_ITERATIONS);
                state_next = ST_R_G4;
            end
            ST_R_G4: begin
                mul_a      = $signed(MUL_W'(pa_reg[2*GREY_W-1:0]));
                mul_b      = $signed(MUL_W'(pa_reg[2*GREY_W-1:0]));
                pb_next    = mul_p[PROD_W-1:0];
                state_next = ST_R_LO;
            end
            ST_R_LO: begin
                mul_a      = $signed(MUL_W'(pb_reg[2*GREY_W-1:0]));
                mul_b      = $signed(MUL_W'(b35_reg));
                pa_next    = mul_p[PROD_W-1:0];
                state_next = ST_R_HI;
            end
            ST_R_HI: begin
                mul_a      = $signed(MUL_W'(pb_reg[4*GREY_W-1:2*GREY_W]));
                mul_b      = $signed(MUL_W'(b35_reg));
                pc_next    = mul_p[PROD_W-1:0];
                state_next = ST_R_CMP;
            end
            ST_R_CMP: begin
                lo_next    = lo_new;
                hi_next    = hi_new;
                state_next = (lo_new == hi_new) ? ST_WRITE : ST_R_G2;
            end
            ST_WRITE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_grey_next  = lo_reg;
                    m_step_next  = step_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            width_reg   <= DIM_RESET;
            height_reg  <= DIM_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_y_reg  <= pix_y_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        zx_reg     <= zx_next;
        zy_reg     <= zy_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        pc_reg     <= pc_next;
        iter_reg   <= iter_next;
        step_reg   <= step_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        b35_reg    <= b35_next;
        m_grey_reg <= m_grey_next;
        m_step_reg <= m_step_next;
    end

    `MEP_ASSERT(a_step_range,
        m_valid |-> (m_escape_step <= STEP_W'(MAX_ITERATIONS)),
        "escape step out of range")
    `MEP_ASSERT(a_grey_zero,
        (m_valid && (m_escape_step == '0 || m_escape_step == STEP_W'(MAX_ITERATIONS)))
            |-> (m_grey == '0),
        "grey not zero for first-step or no escape")
    `MEP_ASSERT(a_iter_bound,
        (state_reg == ST_STEP) |-> (iter_reg < STEP_W'(MAX_ITERATIONS)),
        "orbit step count overran")
    `MEP_ASSERT(a_search_order,
        (state_reg == ST_R_G2) |-> (lo_reg < hi_reg),
        "root search bounds crossed")
    `MEP_ASSERT(a_div_owner,
        div_done |-> (state_reg == ST_DIV_X || state_reg == ST_DIV_Y),
        "divider finished outside a mapping state")
    `MEP_ASSERT_ALWAYS(a_reset_idle,
        !aresetn |=> (state_reg == ST_IDLE && !m_valid),
        "not idle after reset")

endmodule

`default_nettype wire
